// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold in every cycle out of reset
`define PF_ASSERT_NOW(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// check the consequent in the same cycle
`define PF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// check the consequent in the next cycle
`define PF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/pf_pkg.sv =====
// ----------------------------------------------------------------------------
// Playfair stream package
// Constants, command and state types and square geometry helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
	localparam int LETTERS     = 26;
	localparam int CODE_W      = $clog2(LETTERS);
	localparam int POS_W       = $clog2(CELLS + 1);
	localparam int RC_W        = $clog2(SQUARE_SIDE);
	localparam int KIND_W      = 3;
	localparam int CHAR_W      = 8;
	localparam int LETTER_W    = 7;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [RC_W-1:0]   rc_t;

	localparam code_t CODE_I = CODE_W'(8);
	localparam code_t CODE_J = CODE_W'(9);
	localparam code_t CODE_X = CODE_W'(23);

	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_KEY   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FINAL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TEXT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

	localparam logic [CHAR_W-1:0]   ASCII_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0]   ASCII_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0]   ASCII_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0]   ASCII_LOWER_Z = 8'h7A;
	localparam logic [LETTER_W-1:0] LETTER_BASE   = 7'h41;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_KEY,
		OP_FINAL,
		OP_TEXT,
		OP_END
	} op_t;

	typedef struct packed {
		op_t   op;
		code_t code;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_FINAL,
		B_RDPOS,
		B_RDCELL,
		B_HELD,
		B_FIRST,
		B_LAST
	} bstate_t;

	function automatic rc_t pos_row(pos_t p);
		rc_t r;
		r = '0;
		for (int i = 1; i < SQUARE_SIDE; i++) begin
			if (p >= POS_W'(i * SQUARE_SIDE)) begin
				r = RC_W'(i);
			end
		end
		return r;
	endfunction

	function automatic rc_t pos_col(pos_t p);
		pos_t base;
		base = POS_W'(int'(pos_row(p)) * SQUARE_SIDE);
		return RC_W'(p - base);
	endfunction

	function automatic rc_t rc_shift(rc_t v, rc_t sh);
		logic [RC_W:0] sum;
		sum = {1'b0, v} + {1'b0, sh};
		if (sum >= (RC_W + 1)'(SQUARE_SIDE)) begin
			sum = sum - (RC_W + 1)'(SQUARE_SIDE);
		end
		return sum[RC_W-1:0];
	endfunction

	function automatic pos_t cell_index(rc_t r, rc_t c);
		return POS_W'(int'(r) * SQUARE_SIDE + int'(c));
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pf_queue.sv =====
// ----------------------------------------------------------------------------
// Playfair command queue
// Short FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pf_queue import pf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t                slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                push_fire;
	logic                pop_fire;

	assign push_ready = count_q != Q_CNT_W'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pf_front.sv =====
// ----------------------------------------------------------------------------
// Playfair front end
// Accepts input items, folds letters and drops items that do nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pf_front import pf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  logic [CHAR_W-1:0] character,
	output logic              push_valid,
	input  logic              push_ready,
	output cmd_t              push_cmd
);

	logic  valid_s1;
	cmd_t  cmd_s1;
	logic  is_upper;
	logic  is_lower;
	logic  keep;
	code_t raw_code;
	cmd_t  cmd;

	always_comb begin
		is_upper = character inside {[ASCII_UPPER_A:ASCII_UPPER_Z]};
		is_lower = character inside {[ASCII_LOWER_A:ASCII_LOWER_Z]};
		raw_code = is_upper ? CODE_W'(character - ASCII_UPPER_A)
		                    : CODE_W'(character - ASCII_LOWER_A);
		cmd.code = (raw_code == CODE_J) ? CODE_I : raw_code;
		cmd.op   = OP_CLEAR;
		keep     = 1'b0;
		case (kind)
			KIND_CLEAR: begin
				cmd.op = OP_CLEAR;
				keep   = 1'b1;
			end
			KIND_KEY: begin
				cmd.op = OP_KEY;
				keep   = is_upper || is_lower;
			end
			KIND_FINAL: begin
				cmd.op = OP_FINAL;
				keep   = 1'b1;
			end
			KIND_TEXT: begin
				cmd.op = OP_TEXT;
				keep   = is_upper || is_lower;
			end
			KIND_END: begin
				cmd.op = OP_END;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pf_back.sv =====
// ----------------------------------------------------------------------------
// Playfair back end
// Builds the key square and ciphers letter pairs into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pf_back import pf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                encrypt_mode,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  cmd_t                pop_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LETTER_W-1:0] out_letter,
	output logic                last
);

	bstate_t             state_q;
	bstate_t             state_d;
	logic [LETTERS-1:0]  used_q;
	pos_t                fill_q;
	code_t               walk_q;
	logic                pend_valid_q;
	code_t               pend_q;
	code_t               b_q;
	logic                end_q;
	logic                held_valid_q;
	code_t               held_q;
	pos_t                pos_a_q;
	pos_t                pos_b_q;
	code_t               cell_a_q;
	code_t               cell_b_q;
	logic                out_valid_q;
	logic [LETTER_W-1:0] out_letter_q;
	logic                last_q;

	code_t square_mem [CELLS];
	pos_t  pos_mem [LETTERS];

	logic  pop_fire;
	logic  out_free;
	logic  place_req;
	logic  place_en;
	code_t place_code;
	logic  set_pend;
	logic  start_pair;
	code_t pair_code;
	logic  pos_rd;
	logic  cell_rd;
	logic  load_out;
	code_t out_code;
	logic  out_last;
	logic  msg_done;
	rc_t   sh;
	rc_t   ra;
	rc_t   ca;
	rc_t   rb;
	rc_t   cb;
	pos_t  idx_a;
	pos_t  idx_b;

	assign pop_ready = state_q == B_IDLE;
	assign pop_fire  = pop_valid && pop_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		place_code = (state_q == B_FINAL) ? walk_q : pop_cmd.code;
		place_req  = (state_q == B_FINAL && walk_q != CODE_J)
		          || (pop_fire && pop_cmd.op == OP_KEY);
		place_en   = place_req && !used_q[place_code] && fill_q != POS_W'(CELLS);
		set_pend   = pop_fire && pop_cmd.op == OP_TEXT && !pend_valid_q;
		start_pair = pop_fire && pend_valid_q
		          && (pop_cmd.op == OP_TEXT || pop_cmd.op == OP_END);
		pair_code  = (pop_cmd.op == OP_END) ? CODE_X : pop_cmd.code;
	end

	always_comb begin
		sh = encrypt_mode ? RC_W'(1) : RC_W'(SQUARE_SIDE - 1);
		ra = pos_row(pos_a_q);
		ca = pos_col(pos_a_q);
		rb = pos_row(pos_b_q);
		cb = pos_col(pos_b_q);
		if (ra == rb) begin
			idx_a = cell_index(ra, rc_shift(ca, sh));
			idx_b = cell_index(rb, rc_shift(cb, sh));
		end else if (ca == cb) begin
			idx_a = cell_index(rc_shift(ra, sh), ca);
			idx_b = cell_index(rc_shift(rb, sh), cb);
		end else begin
			idx_a = cell_index(ra, cb);
			idx_b = cell_index(rb, ca);
		end
	end

	always_comb begin
		state_d  = state_q;
		pos_rd   = 1'b0;
		cell_rd  = 1'b0;
		load_out = 1'b0;
		out_code = held_q;
		out_last = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					case (pop_cmd.op)
						OP_FINAL: state_d = B_FINAL;
						OP_TEXT:  state_d = pend_valid_q ? B_RDPOS : B_IDLE;
						OP_END:   state_d = pend_valid_q ? B_RDPOS : B_LAST;
						default:  state_d = B_IDLE;
					endcase
				end
			end
			B_FINAL: begin
				if (walk_q == CODE_W'(LETTERS - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_RDPOS: begin
				pos_rd  = 1'b1;
				state_d = B_RDCELL;
			end
			B_RDCELL: begin
				cell_rd = 1'b1;
				state_d = held_valid_q ? B_HELD : B_FIRST;
			end
			B_HELD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = B_FIRST;
				end
			end
			B_FIRST: begin
				out_code = cell_a_q;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = end_q ? B_LAST : B_IDLE;
				end
			end
			B_LAST: begin
				out_last = 1'b1;
				if (held_valid_q && (encrypt_mode || held_q != CODE_X)) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = B_IDLE;
					end
				end else begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
		msg_done = state_q == B_LAST && state_d == B_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			fill_q       <= '0;
			walk_q       <= '0;
			pend_valid_q <= 1'b0;
			held_valid_q <= 1'b0;
			end_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop_fire && pop_cmd.op == OP_CLEAR) begin
				used_q <= '0;
				fill_q <= '0;
			end else if (place_en) begin
				used_q[place_code] <= 1'b1;
				fill_q             <= fill_q + 1'b1;
			end
			if (pop_fire && pop_cmd.op == OP_FINAL) begin
				walk_q <= '0;
			end else if (state_q == B_FINAL) begin
				walk_q <= walk_q + 1'b1;
			end
			if (set_pend) begin
				pend_valid_q <= 1'b1;
			end
			if (start_pair) begin
				end_q <= pop_cmd.op == OP_END;
			end
			if (state_q == B_FIRST && load_out) begin
				held_valid_q <= 1'b1;
				pend_valid_q <= 1'b0;
			end
			if (msg_done) begin
				held_valid_q <= 1'b0;
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (set_pend) begin
			pend_q <= pop_cmd.code;
		end
		if (start_pair) begin
			b_q <= pair_code;
		end
		if (state_q == B_FIRST && load_out) begin
			held_q <= cell_b_q;
		end
		if (load_out) begin
			out_letter_q <= LETTER_BASE + LETTER_W'(out_code);
			last_q       <= out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			square_mem[fill_q[POS_W-1:0]] <= place_code;
			pos_mem[place_code]           <= fill_q;
		end
		if (pos_rd) begin
			pos_a_q <= pos_mem[pend_q];
			pos_b_q <= pos_mem[b_q];
		end
		if (cell_rd) begin
			cell_a_q <= square_mem[idx_a];
			cell_b_q <= square_mem[idx_b];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_letter = out_letter_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// ===== hdl/playfair_cipher_stream_unit.sv =====
// ----------------------------------------------------------------------------
// Playfair cipher stream unit
// 5x5 Playfair square builder and pair cipher with a decoupled front end.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    kind, character
//   out      output     out_valid / out_ready  out_letter, last
//   cfg      input      cfg_valid / cfg_ready  cfg_data (encrypt_mode)
//
// The back end takes key characters and single text letters without leaving idle.
// A letter pair passes position and square reads; the held letter of the last pair,
// if any, then the pair's first letter leave through one output register, and its
// second letter is held. Finalize places each letter but J not yet in the square.
// The front stage and a two-entry command queue keep accepting while the
// back end stalls on the output. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module playfair_cipher_stream_unit import pf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [CHAR_W-1:0]   character,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LETTER_W-1:0] out_letter,
	output logic                last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	logic encrypt_mode_q;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encrypt_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			encrypt_mode_q <= cfg_data;
		end
	end

	pf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.character  (character),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	pf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	pf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.encrypt_mode (encrypt_mode_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_cmd      (pop_cmd),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_letter   (out_letter),
		.last         (last)
	);

endmodule

`default_nettype wire

// ===== hdl/pf_checker.sv =====
// ----------------------------------------------------------------------------
// Playfair port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pf_checker import pf_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [LETTER_W-1:0] out_letter,
	input logic                last,
	input logic                cfg_ready
);

	`PF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_letter) && $stable(last))
	`PF_ASSERT_SAME(a_out_drop_only_on_transfer, $fell(out_valid), $past(out_ready))
	`PF_ASSERT_NEXT(a_no_double_last, out_valid && out_ready && last, !(out_valid && last))
	`PF_ASSERT_NOW(a_cfg_never_stalls, cfg_ready)

endmodule

bind playfair_cipher_stream_unit pf_checker u_pf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_letter (out_letter),
	.last       (last),
	.cfg_ready  (cfg_ready)
);

`default_nettype wire
